### hw/rtl/shi_pkg.sv
`default_nettype none
package shi_pkg;
  localparam int CoordBits = 32;
  localparam int FracBits = 16;
  localparam int TFrac = 30;
  localparam int QBits = TFrac + 1;
  localparam int DistBits = 64;
  localparam int EpsBits = 16;
  localparam int CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    RegNormalX = 3'd0,
    RegNormalY = 3'd1,
    RegNormalZ = 3'd2,
    RegNormalW = 3'd3,
    RegOffsetD = 3'd4,
    RegEpsilon = 3'd5
  } cfg_reg_e;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef coord_t [3:0] vec_t;

  // Plane configuration as seen by the datapath.
  typedef struct packed {
    vec_t normal;
    coord_t offset;
    logic [EpsBits-1:0] eps;
  } plane_t;
endpackage
`default_nettype wire

### hw/rtl/shi_dist.sv
`default_nettype none
// Signed distances of both endpoints: products in one stage, sums in the next.
module shi_dist import shi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  vec_t      from_i,
  input  vec_t      to_i,
  input  plane_t    plane_i,
  output logic signed [DistBits-1:0] df_o,
  output logic signed [DistBits-1:0] dt_o
);
  logic signed [DistBits-1:0] tf_q [4];
  logic signed [DistBits-1:0] tt_q [4];
  logic signed [DistBits-1:0] off_q;

  // A product of two 32-bit values shifted by FracBits never reaches the limit,
  // so truncation toward zero is the only adjustment needed.
  // Negative products get a bias so that the arithmetic shift rounds toward zero.
  function automatic logic signed [DistBits-1:0] term(coord_t n, coord_t p);
    logic signed [2*CoordBits-1:0] pr;
    logic signed [2*CoordBits-1:0] bias;
    pr = n * p;
    bias = pr[2*CoordBits-1] ? (2*CoordBits)'((1 << FracBits) - 1) : '0;
    term = (pr + bias) >>> FracBits;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        tf_q[k] <= term(plane_i.normal[k], from_i[k]);
        tt_q[k] <= term(plane_i.normal[k], to_i[k]);
      end
      off_q <= DistBits'(plane_i.offset);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      df_o <= tf_q[0] + tf_q[1] + tf_q[2] + tf_q[3] - off_q;
      dt_o <= tt_q[0] + tt_q[1] + tt_q[2] + tt_q[3] - off_q;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/shi_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, payload carried along.
module shi_div import shi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  logic [DistBits-1:0] num_i,
  input  logic [DistBits-1:0] den_i,
  input  vec_t from_i,
  input  vec_t to_i,
  input  logic hit_i,
  output logic [QBits-1:0] q_o,
  output vec_t from_o,
  output vec_t to_o,
  output logic hit_o
);
  logic [DistBits:0]   r_q [1:QBits];
  logic [DistBits-1:0] d_q [1:QBits];
  logic [QBits-1:0]    q_q [1:QBits];
  vec_t                f_q [1:QBits];
  vec_t                t_q [1:QBits];
  logic                h_q [1:QBits];

  for (genvar s = 0; s < QBits; s++) begin : g_stage
    logic [DistBits:0]   r_in;
    logic [DistBits-1:0] d_in;
    logic [QBits-1:0]    q_in;
    vec_t                f_in;
    vec_t                t_in;
    logic                h_in;
    logic ge;
    logic [DistBits:0] rem;

    // The first stage takes the inputs, later stages the previous registers.
    if (s == 0) begin : g_first
      assign r_in = {1'b0, num_i};
      assign d_in = den_i;
      assign q_in = '0;
      assign f_in = from_i;
      assign t_in = to_i;
      assign h_in = hit_i;
    end else begin : g_next
      assign r_in = r_q[s];
      assign d_in = d_q[s];
      assign q_in = q_q[s];
      assign f_in = f_q[s];
      assign t_in = t_q[s];
      assign h_in = h_q[s];
    end

    assign ge = r_in >= {1'b0, d_in};
    assign rem = ge ? r_in - {1'b0, d_in} : r_in;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1] <= {rem[DistBits-1:0], 1'b0};
        d_q[s+1] <= d_in;
        q_q[s+1] <= {q_in[QBits-2:0], ge};
        f_q[s+1] <= f_in;
        t_q[s+1] <= t_in;
        h_q[s+1] <= h_in;
      end
    end
  end

  assign q_o = q_q[QBits];
  assign from_o = f_q[QBits];
  assign to_o = t_q[QBits];
  assign hit_o = h_q[QBits];
endmodule
`default_nettype wire

### hw/rtl/shi_lerp.sv
`default_nettype none
// Interpolation: multiply stage, then shift and add stage.
module shi_lerp import shi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  logic [QBits-1:0] q_i,
  input  vec_t from_i,
  input  vec_t to_i,
  input  logic hit_i,
  output vec_t point_o,
  output logic hit_o
);
  logic [CoordBits+QBits-1:0] prod_q [4];
  logic [3:0] neg_q;
  vec_t from_q;
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        logic [CoordBits:0] d;
        d = (to_i[k] < from_i[k])
          ? {from_i[k][CoordBits-1], from_i[k]} - {to_i[k][CoordBits-1], to_i[k]}
          : {to_i[k][CoordBits-1], to_i[k]} - {from_i[k][CoordBits-1], from_i[k]};
        prod_q[k] <= d[CoordBits-1:0] * q_i;
        neg_q[k] <= to_i[k] < from_i[k];
      end
      from_q <= from_i;
      hit_q <= hit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        logic [CoordBits-1:0] st;
        st = CoordBits'(prod_q[k] >> TFrac);
        if (!hit_q) point_o[k] <= '0;
        else point_o[k] <= neg_q[k] ? from_q[k] - st : from_q[k] + st;
      end
      hit_o <= hit_q;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/segment_hyperplane_intersect.sv
`default_nettype none
// Channel | Handshake           | Payload
// in      | in_valid/in_ready   | from_x..w_i, to_x..w_i
// out     | out_valid/out_ready | hit_o, point_x..w_o
// cfg     | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
// One beat enters per cycle when the output is taken.
// The 31-stage quotient pipeline sets the depth.
// Reset clears valid bits and restores register defaults.
// A stall freezes the whole pipeline while the output stage holds a beat.
module segment_hyperplane_intersect import shi_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid,
  output logic in_ready,
  input  coord_t from_x_i, input coord_t from_y_i,
  input  coord_t from_z_i, input coord_t from_w_i,
  input  coord_t to_x_i, input coord_t to_y_i,
  input  coord_t to_z_i, input coord_t to_w_i,
  output logic out_valid,
  input  wire logic out_ready,
  output logic hit_o,
  output coord_t point_x_o, output coord_t point_y_o,
  output coord_t point_z_o, output coord_t point_w_o,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CoordBits-1:0] cfg_data_i
);
  localparam int Depth = 2 + 1 + QBits + 2;
  plane_t plane_q;
  logic [Depth-1:0] vld_q;
  logic en;

  // Pipeline advances unless the final beat is stuck.
  assign en = !(vld_q[Depth-1] && !out_ready);
  assign in_ready = en;
  assign out_valid = vld_q[Depth-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Depth-2:0], in_valid};
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q.normal[0] <= '0;
      plane_q.normal[1] <= '0;
      plane_q.normal[2] <= '0;
      plane_q.normal[3] <= CoordBits'(1) << FracBits;
      plane_q.offset <= '0;
      plane_q.eps <= EpsBits'(1);
    end else if (cfg_valid) begin
      case (cfg_index_i)
        RegNormalX: plane_q.normal[0] <= cfg_data_i;
        RegNormalY: plane_q.normal[1] <= cfg_data_i;
        RegNormalZ: plane_q.normal[2] <= cfg_data_i;
        RegNormalW: plane_q.normal[3] <= cfg_data_i;
        RegOffsetD: plane_q.offset <= cfg_data_i;
        RegEpsilon: plane_q.eps <= cfg_data_i[EpsBits-1:0];
        default: ;
      endcase
    end
  end

  vec_t fin, tin, f1_q, t1_q, f2_q, t2_q, f3_q, t3_q, f4, t4;
  assign fin = {from_w_i, from_z_i, from_y_i, from_x_i};
  assign tin = {to_w_i, to_z_i, to_y_i, to_x_i};
  logic signed [DistBits-1:0] df, dt;

  shi_dist u_dist (.clk_i, .en_i(en), .from_i(fin), .to_i(tin), .plane_i(plane_q),
    .df_o(df), .dt_o(dt));

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q <= fin; t1_q <= tin;
      f2_q <= f1_q; t2_q <= t1_q;
    end
  end

  // Side test and denominator stage.
  logic [DistBits-1:0] num_q, den_q;
  logic hit3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic signed [DistBits-1:0] dn;
      logic [DistBits-1:0] dm;
      dn = df - dt;
      dm = dn[DistBits-1] ? -dn : dn;
      num_q <= df[DistBits-1] ? -df : df;
      den_q <= dm;
      hit3_q <= ((df > 0) != (dt > 0)) && (dm >= DistBits'(plane_q.eps)) && (dm != 0);
      f3_q <= f2_q; t3_q <= t2_q;
    end
  end

  logic [QBits-1:0] q;
  logic h4, hit;
  vec_t pt;
  shi_div u_div (.clk_i, .en_i(en), .num_i(num_q), .den_i(den_q), .from_i(f3_q),
    .to_i(t3_q), .hit_i(hit3_q), .q_o(q), .from_o(f4), .to_o(t4), .hit_o(h4));

  shi_lerp u_lerp (.clk_i, .en_i(en), .q_i(q), .from_i(f4), .to_i(t4), .hit_i(h4),
    .point_o(pt), .hit_o(hit));

  assign hit_o = hit;
  assign point_x_o = pt[0];
  assign point_y_o = pt[1];
  assign point_z_o = pt[2];
  assign point_w_o = pt[3];
endmodule
`default_nettype wire

### hw/rtl/shi_checker.sv
`default_nettype none
// Port-level checks on the result channel.
module shi_checker import shi_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic hit_o,
  input wire logic [CoordBits-1:0] point_x_o,
  input wire logic [CoordBits-1:0] point_w_o
);
  // A waiting result keeps its valid.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("valid dropped");
  // A miss reports zero in the x and w coordinates of the point.
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !hit_o |-> point_x_o == '0 && point_w_o == '0) else $error("miss point");
  // Input is stalled only behind a blocked result.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready) else $error("needless stall");
endmodule

bind segment_hyperplane_intersect shi_checker u_chk (.clk_i, .rst_ni, .in_ready,
  .out_valid, .out_ready, .hit_o, .point_x_o, .point_w_o);
`default_nettype wire
